// ===== rtl/u8u16dec_pkg.sv =====
package u8u16dec_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned UnitW     = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [UnitW-1:0] PlaceholderUnit = 16'h003F;

  // Byte classes as seen at a lead position.
  typedef enum logic [2:0] {
    ClsZero  = 3'd0,
    ClsAscii = 3'd1,
    ClsLead2 = 3'd2,
    ClsLead3 = 3'd3,
    ClsOther = 3'd4
  } byte_cls_e;

  typedef struct packed {
    byte_cls_e        cls;
    logic [ByteW-1:0] data;
    logic             start;
  } byte_item_t;

  function automatic byte_cls_e classify(input logic [ByteW-1:0] b);
    byte_cls_e c;
    if (b == 8'h00) begin
      c = ClsZero;
    end else if (b[7] == 1'b0) begin
      c = ClsAscii;
    end else if ((b & 8'hE0) == 8'hC0) begin
      c = ClsLead2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      c = ClsLead3;
    end else begin
      c = ClsOther;
    end
    return c;
  endfunction

endpackage

// ===== rtl/u8u16dec_front.sv =====
module u8u16dec_front (
  input  logic [u8u16dec_pkg::ByteW-1:0] in_byte_i,
  input  logic                            start_flag_i,
  output u8u16dec_pkg::byte_item_t        item_o
);

  always_comb begin
    item_o.cls   = u8u16dec_pkg::classify(in_byte_i);
    item_o.data  = in_byte_i;
    item_o.start = start_flag_i;
  end

endmodule

// ===== rtl/u8u16dec_fifo.sv =====
module u8u16dec_fifo #(
  parameter int unsigned Depth = u8u16dec_pkg::QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  u8u16dec_pkg::byte_item_t push_item_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic                     empty_o,
  output u8u16dec_pkg::byte_item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u8u16dec_pkg::byte_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/u8u16dec_back.sv =====
module u8u16dec_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  input  u8u16dec_pkg::byte_item_t          item_i,
  output logic                              item_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [u8u16dec_pkg::UnitW-1:0]    code_unit_o,
  output logic                              is_terminator_o
);

  logic [1:0]                       left_q, left_d;
  logic [u8u16dec_pkg::UnitW-1:0]   part_q, part_d;
  logic                             ph_q, ph_d;
  logic                             out_valid_q, out_valid_d;
  logic [u8u16dec_pkg::UnitW-1:0]   unit_q, unit_d;
  logic                             term_q, term_d;

  logic [1:0]                       eff_left;
  logic [u8u16dec_pkg::UnitW-1:0]   eff_part;
  logic [u8u16dec_pkg::UnitW-1:0]   acc_part;
  logic                             eff_ph;
  logic                             emit;
  logic [u8u16dec_pkg::UnitW-1:0]   emit_unit;
  logic                             emit_term;
  logic                             take;

  // The output register frees up in the same cycle that its beat is taken.
  assign take       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = take;

  always_comb begin
    eff_left  = item_i.start ? 2'd0 : left_q;
    eff_part  = item_i.start ? '0 : part_q;
    eff_ph    = item_i.start ? 1'b0 : ph_q;
    acc_part  = eff_ph ? eff_part : {eff_part[9:0], item_i.data[5:0]};
    left_d    = eff_left;
    part_d    = eff_part;
    ph_d      = eff_ph;
    emit      = 1'b0;
    emit_unit = '0;
    emit_term = 1'b0;

    if (eff_left != 2'd0) begin
      left_d = eff_left - 2'd1;
      if (left_d == 2'd0) begin
        emit      = 1'b1;
        emit_unit = eff_ph ? u8u16dec_pkg::PlaceholderUnit : acc_part;
        part_d    = '0;
        ph_d      = 1'b0;
      end else begin
        part_d = acc_part;
      end
    end else begin
      unique case (item_i.cls)
        u8u16dec_pkg::ClsZero: begin
          emit      = 1'b1;
          emit_term = 1'b1;
        end
        u8u16dec_pkg::ClsAscii: begin
          emit      = 1'b1;
          emit_unit = {8'h00, item_i.data};
        end
        u8u16dec_pkg::ClsLead2: begin
          part_d = {11'd0, item_i.data[4:0]};
          ph_d   = 1'b0;
          left_d = 2'd1;
        end
        u8u16dec_pkg::ClsLead3: begin
          part_d = {12'd0, item_i.data[3:0]};
          ph_d   = 1'b0;
          left_d = 2'd2;
        end
        default: begin
          part_d = '0;
          ph_d   = 1'b1;
          left_d = 2'd3;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    unit_d      = unit_q;
    term_d      = term_q;
    if (take && emit) begin
      out_valid_d = 1'b1;
      unit_d      = emit_unit;
      term_d      = emit_term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= 2'd0;
      part_q      <= '0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        left_q <= left_d;
        part_q <= part_d;
        ph_q   <= ph_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    term_q <= term_d;
  end

  assign out_valid_o     = out_valid_q;
  assign code_unit_o     = unit_q;
  assign is_terminator_o = term_q;

endmodule

// ===== rtl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder, one byte per beat in and one 16-bit code unit per beat out.
// Lead bytes below 0x80 give a unit at once, 110xxxxx and 1110xxxx open two- and
// three-byte sequences, and any other lead opens a four-byte skip that gives '?'.
// A zero lead byte gives unit 0 with tuser set, and tuser high on an input beat
// drops any open sequence. The block takes one byte every cycle while the output is not
// stalled; each unit passes through the byte queue and then the output register before
// it is offered, and the queue of QueueDepth entries lets the input keep flowing for
// that many beats while the output is stalled.
module utf8_to_utf16_decoder #(
  parameter int unsigned QueueDepth = u8u16dec_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tuser,  // [0] start_flag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] code_unit
  output logic        m_axis_tuser   // [0] is_terminator
);

  u8u16dec_pkg::byte_item_t in_item;
  u8u16dec_pkg::byte_item_t q_item;
  logic q_full, q_empty, q_pop;

  u8u16dec_front u_front (
    .in_byte_i    (s_axis_tdata),
    .start_flag_i (s_axis_tuser),
    .item_o       (in_item)
  );

  u8u16dec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (q_item)
  );

  assign s_axis_tready = !q_full;

  u8u16dec_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (!q_empty),
    .item_i          (q_item),
    .item_pop_o      (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .code_unit_o     (m_axis_tdata),
    .is_terminator_o (m_axis_tuser)
  );

endmodule
